// ===== rtl/vgm_pkg.sv =====
package vgm_pkg;

  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_WRITE   = 3'd1,
    ACT_WAIT    = 3'd2,
    ACT_LOOP    = 3'd3,
    ACT_UNKNOWN = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    PH_CMD     = 2'd0,
    PH_DATA    = 2'd1,
    PH_WAIT_LO = 2'd2,
    PH_WAIT_HI = 2'd3
  } phase_t;

  localparam logic [1:0] REG_START_POS  = 2'd0;
  localparam logic [1:0] REG_LOOP_POS   = 2'd1;
  localparam logic [1:0] REG_FRAME_WAIT = 2'd2;

  localparam logic [15:0] START_POS_RST  = 16'd64;
  localparam logic [15:0] LOOP_POS_RST   = 16'd64;
  localparam logic [15:0] FRAME_WAIT_RST = 16'd735;

  localparam logic [7:0] OP_CHIP_WRITE = 8'h50;
  localparam logic [7:0] OP_WAIT_N     = 8'h61;
  localparam logic [7:0] OP_WAIT_FRAME = 8'h62;
  localparam logic [7:0] OP_END_LOOP   = 8'h66;
  localparam logic [3:0] OP_WAIT_SHORT = 4'h7;

  typedef struct packed {
    action_t     action;
    logic [7:0]  write_value;
    logic [15:0] wait_samples;
    logic [15:0] next_address;
  } result_t;

endpackage

// ===== rtl/vgm_decode.sv =====
module vgm_decode #(
  parameter int ADDR_BITS = 16
) (
  input  vgm_pkg::phase_t        phase,
  input  logic [7:0]             wait_lo,
  input  logic [ADDR_BITS-1:0]   read_pos,
  input  logic [7:0]             stream_byte,
  input  logic [ADDR_BITS-1:0]   loop_pos,
  input  logic [15:0]            frame_wait,
  output vgm_pkg::phase_t        phase_nxt,
  output logic [7:0]             wait_lo_nxt,
  output logic [ADDR_BITS-1:0]   read_pos_nxt,
  output vgm_pkg::result_t       res
);

  logic [ADDR_BITS-1:0] pos_inc;
  logic [ADDR_BITS+15:0] pos_wide;

  assign pos_inc  = read_pos + ADDR_BITS'(1);
  assign pos_wide = {16'd0, read_pos_nxt};

  always_comb begin
    phase_nxt        = vgm_pkg::PH_CMD;
    wait_lo_nxt      = wait_lo;
    read_pos_nxt     = pos_inc;
    res.action       = vgm_pkg::ACT_NONE;
    res.write_value  = 8'd0;
    res.wait_samples = 16'd0;
    unique case (phase)
      vgm_pkg::PH_DATA: begin
        res.action      = vgm_pkg::ACT_WRITE;
        res.write_value = stream_byte;
      end
      vgm_pkg::PH_WAIT_LO: begin
        wait_lo_nxt = stream_byte;
        phase_nxt   = vgm_pkg::PH_WAIT_HI;
      end
      vgm_pkg::PH_WAIT_HI: begin
        res.action       = vgm_pkg::ACT_WAIT;
        res.wait_samples = {stream_byte, wait_lo};
      end
      default: begin
        if (stream_byte == vgm_pkg::OP_CHIP_WRITE) begin
          phase_nxt = vgm_pkg::PH_DATA;
        end else if (stream_byte == vgm_pkg::OP_WAIT_N) begin
          phase_nxt = vgm_pkg::PH_WAIT_LO;
        end else if (stream_byte == vgm_pkg::OP_WAIT_FRAME) begin
          res.action       = vgm_pkg::ACT_WAIT;
          res.wait_samples = frame_wait;
        end else if (stream_byte[7:4] == vgm_pkg::OP_WAIT_SHORT) begin
          res.action       = vgm_pkg::ACT_WAIT;
          res.wait_samples = 16'(stream_byte[3:0]) + 16'd1;
        end else if (stream_byte == vgm_pkg::OP_END_LOOP) begin
          res.action   = vgm_pkg::ACT_LOOP;
          read_pos_nxt = loop_pos;
        end else begin
          res.action = vgm_pkg::ACT_UNKNOWN;
        end
      end
    endcase
    res.next_address = pos_wide[15:0];
  end

endmodule

// ===== rtl/vgm_out_reg.sv =====
module vgm_out_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  vgm_pkg::result_t res,
  input  logic             out_stall,
  output logic             busy,
  output logic             out_valid,
  output vgm_pkg::result_t out_res
);

  logic             valid_r;
  logic             valid_nxt;
  vgm_pkg::result_t res_r;

  assign busy      = valid_r & out_stall;
  assign valid_nxt = load | busy;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule

// ===== rtl/vgm_command_stream_parser.sv =====
// a result is registered and appears in the cycle after its request is accepted
// throughput: one stream byte per cycle while the output is not stalled, set by the single result register
// in_stall is high only while a held result is stalled at the output
// synchronous active-low reset: phase to command, read position and registers
// to their defaults (start 64, loop 64, frame wait 735), output empty
module vgm_command_stream_parser #(
  parameter int ADDR_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_stream_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_action,
  output logic [7:0]  out_write_value,
  output logic [15:0] out_wait_samples,
  output logic [15:0] out_next_address,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  vgm_pkg::phase_t      phase_r, phase_nxt, phase_dec;
  logic [7:0]           wait_lo_r, wait_lo_nxt;
  logic [ADDR_BITS-1:0] pos_r, pos_nxt, pos_dec;
  logic [ADDR_BITS-1:0] loop_pos_r;
  logic [15:0]          frame_wait_r;
  logic [ADDR_BITS+15:0] cfg_wide;
  logic [ADDR_BITS+15:0] rst_start_wide;
  logic [ADDR_BITS+15:0] rst_loop_wide;
  logic                 accept;
  logic                 busy;
  vgm_pkg::result_t     dec_res;
  vgm_pkg::result_t     out_res;

  assign cfg_wide       = {{ADDR_BITS{1'b0}}, cfg_wdata};
  assign rst_start_wide = {{ADDR_BITS{1'b0}}, vgm_pkg::START_POS_RST};
  assign rst_loop_wide  = {{ADDR_BITS{1'b0}}, vgm_pkg::LOOP_POS_RST};
  assign in_stall       = busy;
  assign accept         = in_valid & ~busy;

  vgm_decode #(.ADDR_BITS(ADDR_BITS)) u_decode (
    .phase        (phase_r),
    .wait_lo      (wait_lo_r),
    .read_pos     (pos_r),
    .stream_byte  (in_stream_byte),
    .loop_pos     (loop_pos_r),
    .frame_wait   (frame_wait_r),
    .phase_nxt    (phase_dec),
    .wait_lo_nxt  (wait_lo_nxt),
    .read_pos_nxt (pos_dec),
    .res          (dec_res)
  );

  vgm_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .res       (dec_res),
    .out_stall (out_stall),
    .busy      (busy),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    if (cfg_we && cfg_index == vgm_pkg::REG_START_POS) begin
      phase_nxt = vgm_pkg::PH_CMD;
      pos_nxt   = cfg_wide[ADDR_BITS-1:0];
    end else if (accept) begin
      phase_nxt = phase_dec;
      pos_nxt   = pos_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= vgm_pkg::PH_CMD;
      wait_lo_r    <= 8'd0;
      pos_r        <= rst_start_wide[ADDR_BITS-1:0];
      loop_pos_r   <= rst_loop_wide[ADDR_BITS-1:0];
      frame_wait_r <= vgm_pkg::FRAME_WAIT_RST;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      if (accept) begin
        wait_lo_r <= wait_lo_nxt;
      end
      if (cfg_we && cfg_index == vgm_pkg::REG_LOOP_POS) begin
        loop_pos_r <= cfg_wide[ADDR_BITS-1:0];
      end
      if (cfg_we && cfg_index == vgm_pkg::REG_FRAME_WAIT) begin
        frame_wait_r <= cfg_wdata;
      end
    end
  end

  assign out_action       = out_res.action;
  assign out_write_value  = out_res.write_value;
  assign out_wait_samples = out_res.wait_samples;
  assign out_next_address = out_res.next_address;

endmodule

// ===== rtl/vgm_checker.sv =====
module vgm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_action,
  input logic [7:0]  out_write_value,
  input logic [15:0] out_wait_samples,
  input logic [15:0] out_next_address
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_action_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_action == vgm_pkg::ACT_NONE || out_action == vgm_pkg::ACT_WRITE ||
                   out_action == vgm_pkg::ACT_WAIT || out_action == vgm_pkg::ACT_LOOP ||
                   out_action == vgm_pkg::ACT_UNKNOWN))
    else $error("action code out of range");

  a_write_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_action != vgm_pkg::ACT_WRITE) |-> out_write_value == 8'd0)
    else $error("write value set without chip write");

  a_wait_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_action != vgm_pkg::ACT_WAIT) |-> out_wait_samples == 16'd0)
    else $error("wait count set without wait");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_action) &&
                                  $stable(out_next_address)))
    else $error("stalled result changed");

endmodule

bind vgm_command_stream_parser vgm_checker u_vgm_checker (.*);
